// ----- rtl/kpe_pkg.sv -----
// Package of the k-permutation enumerator: size defaults, result status codes,
// register indexes, sequencer states and the configuration bundle.
// No dependencies; used by kpe_cfg_regs and k_permutation_enumerator_unit.
package kpe_pkg;

  // Default sizes of the option bitmap and the slot array.
  localparam int unsigned MaxOptionsDefault = 32;
  localparam int unsigned MaxPickDefault    = 16;

  // Status codes carried by each result beat.
  localparam logic [1:0] StatusElement   = 2'd0;
  localparam logic [1:0] StatusExhausted = 2'd1;
  localparam logic [1:0] StatusBadConfig = 2'd2;

  // Configuration address width and register indexes (index is paddr[2]).
  localparam int unsigned CfgAddrW       = 3;
  localparam logic        RegOptionCount = 1'b0;
  localparam logic        RegPickCount   = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StSlot,
    StScan,
    StEmit,
    StOut
  } seq_state_e;

  // Configuration values plus a one-cycle write strobe.
  typedef struct packed {
    logic [5:0] option_count;
    logic [4:0] pick_count;
    logic       wr;
  } cfg_t;

endpackage

// ----- rtl/kpe_cfg_regs.sv -----
// Configuration registers of the k-permutation enumerator behind an APB-style port.
// Depends on kpe_pkg for the register indexes and the cfg_t bundle.
module kpe_cfg_regs import kpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [5:0] option_count_q;
  logic [4:0] pick_count_q;
  logic       wr;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes; every address decodes to one of the two registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      option_count_q <= 6'd1;
      pick_count_q   <= 5'd1;
    end else if (wr) begin
      case (paddr[2])
        RegOptionCount: option_count_q <= pwdata[5:0];
        RegPickCount:   pick_count_q   <= pwdata[4:0];
        default:        ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (paddr[2])
      RegOptionCount: prdata = {26'd0, option_count_q};
      RegPickCount:   prdata = {27'd0, pick_count_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o.option_count = option_count_q;
  assign cfg_o.pick_count   = pick_count_q;
  assign cfg_o.wr           = wr;

endmodule

// ----- rtl/k_permutation_enumerator_unit.sv -----
// Top level of the lexicographic k-permutation enumerator: backtracking sequencer,
// slot array, option bitmap and output register. Depends on kpe_pkg, kpe_cfg_regs.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  restart_i
//   out      output     out_valid_o / out_stall_i element_value_o, element_position_o,
//                                                last_element_o, status_o
//   cfg      input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// StCheck checks an accepted request. Each slot visited passes StSlot, then StScan,
// which tests candidate options one at a time in the shared compare/increment step
// until one is free or they run out. Element beats pass StEmit, then StOut; status
// beats pass only StOut. Reset clears the search state at once; a config write or
// a restart does too. A stalled output beat holds the sequencer; no request is taken
// until the last beat of the current one has been delivered.
module k_permutation_enumerator_unit import kpe_pkg::*; #(
  parameter int unsigned MAX_OPTIONS = MaxOptionsDefault,
  parameter int unsigned MAX_PICK    = MaxPickDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [4:0]          element_value_o,
  output logic [3:0]          element_position_o,
  output logic                last_element_o,
  output logic [1:0]          status_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int unsigned OW = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_OPTIONS + 1);
  localparam logic [6:0] MaxPickW = 7'(MAX_PICK);
  localparam logic [6:0] MaxOptW  = 7'(MAX_OPTIONS);

  cfg_t cfg;

  kpe_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  seq_state_e state_q, state_d;

  logic [MAX_PICK-1:0]    slot_valid_q;
  logic [MAX_OPTIONS-1:0] used_q;
  logic [IW-1:0]          pos_q;
  logic [IW-1:0]          cursor_q;
  logic [IW-1:0]          out_idx_q;
  logic                   finished_q;
  logic [OW-1:0]          slot_choice_q [MAX_PICK];
  logic [CW-1:0]          cand_q;
  logic [4:0]             val_q;
  logic [3:0]             epos_q;
  logic                   last_q;
  logic [1:0]             status_q;

  logic          in_acc;
  logic          out_acc;
  logic          clear;
  logic          bad_cfg;
  logic [4:0]    k_m1;
  logic          pos_last;
  logic          pos_zero;
  logic          cand_end;
  logic          cand_used;
  logic          idx_last;
  logic [IW-1:0] rd_idx;
  logic [OW-1:0] rd_choice;
  logic [IW-1:0] start_pos;
  logic [5:0]    choice6;
  logic [7:0]    idx8;

  // Handshakes and state clearing.
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign clear   = cfg.wr || (in_acc && restart_i);

  // Configuration checks and the shared compare step of the search.
  assign bad_cfg   = (cfg.pick_count == 5'd0) ||
                     ({1'b0, cfg.pick_count} > cfg.option_count) ||
                     (7'(cfg.pick_count) > MaxPickW) ||
                     (7'(cfg.option_count) > MaxOptW);
  assign k_m1      = cfg.pick_count - 5'd1;
  assign pos_last  = (7'(pos_q) == 7'(k_m1));
  assign pos_zero  = (pos_q == '0);
  assign start_pos = (7'(cursor_q) > 7'(k_m1)) ? IW'(k_m1) : cursor_q;
  assign cand_end  = (7'(cand_q) >= 7'(cfg.option_count));
  assign cand_used = used_q[cand_q[OW-1:0]];
  assign idx_last  = (7'(out_idx_q) == 7'(k_m1));

  // Single read port of the slot array.
  assign rd_idx    = (state_q == StEmit) ? out_idx_q : pos_q;
  assign rd_choice = slot_choice_q[rd_idx];
  assign choice6   = 6'(rd_choice);
  assign idx8      = 8'(out_idx_q);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) state_d = StCheck;
      end
      StCheck: begin
        if (bad_cfg || finished_q) state_d = StOut;
        else                       state_d = StSlot;
      end
      StSlot: state_d = StScan;
      StScan: begin
        if (cand_end) begin
          state_d = pos_zero ? StOut : StSlot;
        end else if (!cand_used) begin
          state_d = pos_last ? StEmit : StSlot;
        end
      end
      StEmit: state_d = StOut;
      StOut: begin
        if (out_acc) state_d = last_q ? StIdle : StEmit;
      end
      default: state_d = StIdle;
    endcase
  end

  // Handshake and payload outputs.
  always_comb begin
    in_stall_o         = (state_q != StIdle);
    out_valid_o        = (state_q == StOut);
    element_value_o    = val_q;
    element_position_o = epos_q;
    last_element_o     = last_q;
    status_o           = status_q;
  end

  // Control state: search position, slot valid bits, option bitmap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      slot_valid_q <= '0;
      used_q       <= '0;
      pos_q        <= '0;
      cursor_q     <= '0;
      out_idx_q    <= '0;
      finished_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear) begin
        slot_valid_q <= '0;
        used_q       <= '0;
        cursor_q     <= '0;
        finished_q   <= 1'b0;
      end
      case (state_q)
        StCheck: begin
          if (!bad_cfg && !finished_q) pos_q <= start_pos;
        end
        StSlot: begin
          // Give back the option this slot held before trying the next one.
          if (slot_valid_q[pos_q]) used_q[rd_choice] <= 1'b0;
        end
        StScan: begin
          if (cand_end) begin
            slot_valid_q[pos_q] <= 1'b0;
            if (pos_zero) begin
              finished_q <= 1'b1;
              cursor_q   <= '0;
            end else begin
              pos_q <= pos_q - IW'(1);
            end
          end else if (!cand_used) begin
            slot_valid_q[pos_q]       <= 1'b1;
            used_q[cand_q[OW-1:0]]    <= 1'b1;
            if (pos_last) begin
              cursor_q  <= pos_q;
              out_idx_q <= '0;
            end else begin
              pos_q <= pos_q + IW'(1);
            end
          end
        end
        StOut: begin
          if (out_acc && !last_q) out_idx_q <= out_idx_q + IW'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers: candidate, slot contents and the output beat.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StCheck: begin
        val_q  <= 5'd0;
        epos_q <= 4'd0;
        last_q <= 1'b1;
        if (bad_cfg) status_q <= StatusBadConfig;
        else         status_q <= StatusExhausted;
      end
      StSlot: begin
        cand_q <= slot_valid_q[pos_q] ? CW'(rd_choice) + CW'(1) : '0;
      end
      StScan: begin
        if (cand_end) begin
          val_q    <= 5'd0;
          epos_q   <= 4'd0;
          last_q   <= 1'b1;
          status_q <= StatusExhausted;
        end else if (cand_used) begin
          cand_q <= cand_q + CW'(1);
        end else begin
          slot_choice_q[pos_q] <= cand_q[OW-1:0];
        end
      end
      StEmit: begin
        val_q    <= choice6[4:0];
        epos_q   <= idx8[3:0];
        last_q   <= idx_last;
        status_q <= StatusElement;
      end
      default: ;
    endcase
  end

  // A request is taken only when no result beat is pending.
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("request taken while a result beat is pending");

  // Status beats are single, marked last and carry zero fields.
  a_status_beat_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StatusElement) |->
      last_element_o && (element_value_o == 5'd0) && (element_position_o == 4'd0))
    else $error("malformed status beat");

  // After the last beat of a request the block is ready again.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_element_o |=> !in_stall_o)
    else $error("block not ready after the last beat");

  // The search position stays inside the permutation.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSlot || state_q == StScan) |-> (7'(pos_q) <= 7'(k_m1)))
    else $error("search position beyond the pick count");

endmodule
